// ----- hdl/char_key_hash_table_quadratic_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte-keyed hash table
// Shorthand for clocked implication checks, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_KEY_HASH_TABLE_QUADRATIC_MACROS_SVH
`define CHAR_KEY_HASH_TABLE_QUADRATIC_MACROS_SVH

// Same-cycle implication: cond holds whenever trig holds.
`define CKHT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("same-cycle check failed");

// Next-cycle implication: cond holds in the cycle after trig.
`define CKHT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/ckht_pkg.sv -----
// ---------------------------------------------------------------------------
// ckht_pkg
// Shared widths, request codes, status codes and slot states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ckht_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 8;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;
  localparam int SST_W    = 2;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd52;

  // request kinds
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  // slot states
  localparam logic [SST_W-1:0] SST_EMPTY   = 2'd0;
  localparam logic [SST_W-1:0] SST_LIVE    = 2'd1;
  localparam logic [SST_W-1:0] SST_DELETED = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/char_key_hash_table_quadratic.sv -----
// Each request makes up to SLOTS probes, one at a time: a slot-memory read (S_READ), then
//   a compare (S_CHECK) through the single probe/compare unit. The unused code skips probing.
// A result waits in S_DONE until the output register is free; in_ready stays low from
//   the input transfer until the result is loaded, so one request is in flight at a time.
// Reset (rst_n low, synchronous): clears control state, then a clearing pass marks
//   every slot empty; in_ready stays low until it ends.
// ---------------------------------------------------------------------------
// char_key_hash_table_quadratic
// Open-addressing hash table with byte keys and triangular quadratic probing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_key_hash_table_quadratic
  import ckht_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write channel (max_entries)
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_W-1:0]    cfg_data,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [DATA_W-1:0]   in_value_in,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DATA_W-1:0]        out_value_out,
  output logic [CNT_W-1:0]         out_live_count
);

  // Address and row layout: {state, key, value}.
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW    = SST_W + KEY_W + VALUE_BITS;

  // Sequencer codes.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Control state.
  logic [2:0]          state_r,     state_nxt;
  logic [AW-1:0]       clr_r,       clr_nxt;
  logic [CNT_W-1:0]    cnt_r,       cnt_nxt;
  logic [CNT_W-1:0]    max_r,       max_nxt;
  logic                free_v_r,    free_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request payload and probe position.
  logic [OP_W-1:0]       op_r,         op_nxt;
  logic [KEY_W-1:0]      key_r,        key_nxt;
  logic [VALUE_BITS-1:0] val_r,        val_nxt;
  logic [AW-1:0]         slot_r,       slot_nxt;
  logic [AW-1:0]         att_r,        att_nxt;
  logic [AW-1:0]         free_slot_r,  free_slot_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [DATA_W-1:0]     res_value_r,  res_value_nxt;
  logic [CNT_W-1:0]      res_count_r,  res_count_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [DATA_W-1:0]     out_value_r,  out_value_nxt;
  logic [CNT_W-1:0]      out_count_r,  out_count_nxt;

  // Slot memory: one write port, one registered read port at slot_r.
  logic [RW-1:0] slot_mem [SLOTS];
  logic [RW-1:0] rd_row_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_row;
    end
    rd_row_r <= slot_mem[slot_r];
  end

  // Home slot: key mod SLOTS by reciprocal multiplication. A 17-bit scale keeps
  // the quotient exact for every byte key at any table size.
  localparam int HOME_SH = 17;
  localparam int HOME_M  = ((1 << HOME_SH) + SLOTS - 1) / SLOTS;
  localparam int PROD_W  = KEY_W + HOME_SH;

  logic [PROD_W-1:0] home_prod;
  logic [KEY_W-1:0]  home_q;
  logic [PROD_W-1:0] key_rem;
  logic [AW-1:0]     home_slot;

  assign home_prod = PROD_W'(in_key) * PROD_W'(HOME_M);
  assign home_q    = home_prod[HOME_SH +: KEY_W];
  assign key_rem   = PROD_W'(in_key) - PROD_W'(home_q) * PROD_W'(SLOTS);
  assign home_slot = key_rem[AW-1:0];

  // Fields of the row just read.
  logic [SST_W-1:0]      row_state;
  logic [KEY_W-1:0]      row_key;
  logic [VALUE_BITS-1:0] row_val;
  logic                  row_live;
  logic                  row_empty;
  logic                  row_hit;
  logic                  last_probe;
  logic                  free_now_v;
  logic [AW-1:0]         free_now_slot;

  assign row_state     = rd_row_r[RW-1 -: SST_W];
  assign row_key       = rd_row_r[RW-SST_W-1 -: KEY_W];
  assign row_val       = rd_row_r[VALUE_BITS-1:0];
  assign row_live      = (row_state == SST_LIVE);
  assign row_empty     = (row_state == SST_EMPTY);
  assign row_hit       = row_live && (row_key == key_r);
  assign last_probe    = (att_r == AW'(SLOTS - 1));
  // Remember the first reusable slot on the path, counting the one just read.
  assign free_now_v    = free_v_r || !row_live;
  assign free_now_slot = free_v_r ? free_slot_r : slot_r;

  // Next probe: slot + (attempt + 1), folded back below SLOTS with one subtract.
  logic [AW:0] step;
  logic [AW:0] slot_sum;
  logic [AW:0] slot_adv;

  assign step     = {1'b0, att_r} + (AW+1)'(1);
  assign slot_sum = {1'b0, slot_r} + step;
  assign slot_adv = (slot_sum >= (AW+1)'(SLOTS)) ? slot_sum - (AW+1)'(SLOTS) : slot_sum;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    max_nxt        = max_r;
    free_v_nxt     = free_v_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    att_nxt        = att_r;
    free_slot_nxt  = free_slot_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_count_nxt  = res_count_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = slot_r;
    wr_row         = {SST_LIVE, key_r, val_r};

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration is taken in any state.
    if (cfg_valid) begin
      max_nxt = cfg_data;
    end

    case (state_r)
      S_CLEAR: begin
        // Sweep the memory, marking each slot empty.
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_row  = {SST_EMPTY, KEY_W'(0), VALUE_BITS'(0)};
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          key_nxt       = in_key;
          val_nxt       = VALUE_BITS'(in_value_in);
          slot_nxt      = home_slot;
          att_nxt       = '0;
          free_v_nxt    = 1'b0;
          res_value_nxt = '0;
          res_count_nxt = cnt_r;
          if (in_op == OP_INSERT || in_op == OP_LOOKUP || in_op == OP_REMOVE) begin
            state_nxt = S_READ;
          end else begin
            // Unused code: answer not found, touch nothing.
            res_status_nxt = STATUS_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      S_READ: begin
        // Row at slot_r lands in rd_row_r at this edge.
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (op_r == OP_INSERT) begin
          if (row_hit) begin
            // Existing key: overwrite the value in place.
            wr_en          = 1'b1;
            wr_addr        = slot_r;
            res_status_nxt = STATUS_OK;
            state_nxt      = S_DONE;
          end else if (row_empty || last_probe) begin
            if ((cnt_r >= max_r) || !free_now_v) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = free_now_slot;
              cnt_nxt        = cnt_r + CNT_W'(1);
              res_status_nxt = STATUS_OK;
            end
            state_nxt = S_DONE;
          end else begin
            free_v_nxt    = free_now_v;
            free_slot_nxt = free_now_slot;
            att_nxt       = att_r + AW'(1);
            slot_nxt      = slot_adv[AW-1:0];
            state_nxt     = S_READ;
          end
        end else begin
          if (row_hit) begin
            if (op_r == OP_LOOKUP) begin
              res_value_nxt = DATA_W'(row_val);
            end else begin
              // Leave a deleted mark so later probe chains pass through.
              wr_en   = 1'b1;
              wr_addr = slot_r;
              wr_row  = {SST_DELETED, row_key, row_val};
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            res_status_nxt = STATUS_OK;
            state_nxt      = S_DONE;
          end else if (row_empty || last_probe) begin
            res_status_nxt = STATUS_NOTFOUND;
            state_nxt      = S_DONE;
          end else begin
            att_nxt   = att_r + AW'(1);
            slot_nxt  = slot_adv[AW-1:0];
            state_nxt = S_READ;
          end
        end
        res_count_nxt = cnt_nxt;
      end

      S_DONE: begin
        // Hold until the output register is free, then load it.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = res_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      max_r       <= MAX_ENTRIES_RST;
      free_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      free_v_r    <= free_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    att_r        <= att_nxt;
    free_slot_r  <= free_slot_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_live_count = out_count_r;

endmodule

`default_nettype wire

// ----- hdl/ckht_checker.sv -----
// ---------------------------------------------------------------------------
// ckht_checker
// Port-level checks for the hash table, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "char_key_hash_table_quadratic_macros.svh"

module ckht_checker
  import ckht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [DATA_W-1:0]   out_value_out,
  input wire logic [CNT_W-1:0]    out_live_count
);

  // one request at a time: busy right after a transfer in
  `CKHT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // failed answers (status other than OK) carry a zero value
  `CKHT_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && (out_status != STATUS_OK), out_value_out == '0)

  // live count never exceeds the table size
  `CKHT_ASSERT_SAME(a_count_bound, clk, rst_n, out_valid, int'(out_live_count) <= SLOTS)

  // stalled result holds
  `CKHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_value_out) && $stable(out_live_count))

endmodule

bind char_key_hash_table_quadratic ckht_checker #(.SLOTS(SLOTS)) u_ckht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_value_out  (out_value_out),
  .out_live_count (out_live_count)
);

`default_nettype wire

// ----- tb/char_key_hash_table_quadratic_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_key_hash_table_quadratic_tb
// Drives insert, lookup and remove requests into the byte-keyed hash table
// and checks every response against a scoreboard table kept in the bench.
// The capacity limit is reprogrammed between phases. Both handshakes get
// random gaps, and one long output stall backs the table up.
// ---------------------------------------------------------------------------

module char_key_hash_table_quadratic_tb;
  import ckht_pkg::*;

  // Request code that the table ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    count;
  } table_reply_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = OP_LOOKUP;
  logic [KEY_W-1:0]  in_key = '0;
  logic [DATA_W-1:0] in_value_in = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_value_out;
  logic [CNT_W-1:0]    out_live_count;

  char_key_hash_table_quadratic DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value_in    (in_value_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_live_count (out_live_count)
  );

  // Requests waiting to be driven, and responses the table still owes us
  table_req_t   pending_reqs[$];
  table_reply_t expected_replies[$];

  // Scoreboard copy of the table contents and the capacity register
  logic [SST_W-1:0]  slot_mark [SLOTS_DEF];
  logic [KEY_W-1:0]  slot_tag  [SLOTS_DEF];
  logic [DATA_W-1:0] slot_word [SLOTS_DEF];
  logic [CNT_W-1:0]  live_entries;
  logic [CNT_W-1:0]  cap_entries;

  // Transfer flags from the last rising edge, for the falling-edge drivers
  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  logic cfg_took = 1'b0;

  int failures = 0;
  int send_gap_max = 16;
  int recv_gap_max = 16;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  table_req_t   next_req;
  table_reply_t want;

  // -------------------------------------------------------------------------
  // Scoreboard table
  // -------------------------------------------------------------------------

  // Triangular probe sequence: home slot plus i*(i+1)/2, wrapped to the table
  function automatic int probe_at(logic [KEY_W-1:0] key, int attempt);
    return (int'(key) + attempt * (attempt + 1) / 2) % SLOTS_DEF;
  endfunction

  // Walk the probe chain for a live copy of key; an empty slot ends the chain,
  // deleted slots are stepped over
  function automatic int find_key(logic [KEY_W-1:0] key);
    int s;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      s = probe_at(key, i);
      if (slot_mark[s] == SST_EMPTY) return -1;
      if (slot_mark[s] == SST_LIVE && slot_tag[s] == key) return s;
    end
    return -1;
  endfunction

  // Apply one request to the scoreboard table and return the response it owes
  function automatic table_reply_t table_apply(table_req_t req);
    table_reply_t r;
    int s;
    int free_slot;
    bit hit;
    r.status  = STATUS_NOTFOUND;
    r.value   = '0;
    free_slot = -1;
    hit       = 1'b0;
    case (req.op)
      OP_INSERT: begin
        // Overwrite a live copy anywhere on the chain; otherwise remember the
        // first reusable slot and stop at the first empty one
        for (int i = 0; i < SLOTS_DEF; i++) begin
          s = probe_at(req.key, i);
          if (slot_mark[s] == SST_LIVE) begin
            if (slot_tag[s] == req.key) begin
              slot_word[s] = req.value;
              hit = 1'b1;
              break;
            end
          end else begin
            if (free_slot < 0) free_slot = s;
            if (slot_mark[s] == SST_EMPTY) break;
          end
        end
        if (hit) begin
          r.status = STATUS_OK;
        end else if (live_entries >= cap_entries || free_slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          slot_mark[free_slot] = SST_LIVE;
          slot_tag[free_slot]  = req.key;
          slot_word[free_slot] = req.value;
          live_entries = live_entries + 1'b1;
          r.status = STATUS_OK;
        end
      end
      OP_LOOKUP: begin
        s = find_key(req.key);
        if (s >= 0) begin
          r.status = STATUS_OK;
          r.value  = slot_word[s];
        end
      end
      OP_REMOVE: begin
        // Leave a tombstone so chains running through this slot stay intact
        s = find_key(req.key);
        if (s >= 0) begin
          slot_mark[s] = SST_DELETED;
          if (live_entries != 0) live_entries = live_entries - 1'b1;
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    r.count = live_entries;
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      failures++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Monitor: sample all three channels at the rising edge. Check an output
  // transfer before predicting an input transfer of the same edge, so a
  // stray response can never pair with a request taken on that edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
      cfg_took <= 1'b0;
      foreach (slot_mark[i]) slot_mark[i] = SST_EMPTY;
      live_entries = '0;
      cap_entries  = MAX_ENTRIES_RST;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) cap_entries = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("response with nothing outstanding: status %0d value 0x%0h count %0d",
                 out_status, out_value_out, out_live_count);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_status));
          check_field("value_out", want.value, out_value_out);
          check_field("live_count", DATA_W'(want.count), DATA_W'(out_live_count));
        end
      end
      if (in_valid && in_ready)
        expected_replies.push_back(table_apply('{in_op, in_key, in_value_in}));
    end
  end

  // -------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge. Hold the payload until
  // the transfer, then draw a gap; with no gap and more work, keep valid high
  // and swap the payload in one assignment.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else if (!(in_valid && !in_took)) begin
      if (in_valid) send_wait = $urandom_range(0, send_gap_max);
      if (send_wait == 0 && pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_op       <= next_req.op;
        in_key      <= next_req.key;
        in_value_in <= next_req.value;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Response sink: draw a stall after every transfer. A long hold requested
  // by the stimulus is counted down here, while requests keep coming.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (out_took) recv_wait = $urandom_range(0, recv_gap_max);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic queue_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [DATA_W-1:0] value);
    pending_reqs.push_back('{op, key, value});
  endtask

  // Block until the table is idle: nothing left to send, nothing in flight.
  // Step past the falling edge so the driver's update is visible.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  task automatic write_cap(logic [CNT_W-1:0] cap);
    @(negedge clk);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // Random mix; about half the keys crowd onto eight home slots so chains,
  // tombstones and collisions stay busy, the rest spread over key_span.
  task automatic queue_mix(int count, int key_span, int ins_pct);
    int pick;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < 3 + ins_pct) op = OP_INSERT;
      else if (pick < 3 + ins_pct + (97 - ins_pct) * 6 / 10) op = OP_LOOKUP;
      else op = OP_REMOVE;
      if ($urandom_range(0, 1) == 0)
        key = KEY_W'(($urandom_range(0, 3) << 6) | $urandom_range(0, 7));
      else
        key = KEY_W'($urandom_range(0, key_span - 1));
      queue_req(op, key, $urandom());
    end
  endtask

  // Drain, reprogram the cap, set both gap limits, then load the next batch
  task automatic run_phase(int cap, int count, int key_span, int ins_pct,
                           int gap_in, int gap_out);
    wait_drained();
    write_cap(CNT_W'(cap));
    send_gap_max = gap_in;
    recv_gap_max = gap_out;
    queue_mix(count, key_span, ins_pct);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset cap: misses on an empty table, the
    // ignored code, overwrite, a chain of keys sharing home slot zero,
    // lookup through a tombstone and reuse of it, extremes of key and value
    queue_req(OP_LOOKUP, 8'd0,   32'h0);
    queue_req(OP_REMOVE, 8'd255, 32'h0);
    queue_req(OP_UNUSED, 8'd255, 32'hFFFF_FFFF);
    queue_req(OP_INSERT, 8'd0,   32'h0);
    queue_req(OP_INSERT, 8'd0,   32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 8'd0,   32'h0);
    queue_req(OP_INSERT, 8'd64,  32'h1234_5678);
    queue_req(OP_INSERT, 8'd128, 32'hA5A5_A5A5);
    queue_req(OP_LOOKUP, 8'd128, 32'h0);
    queue_req(OP_REMOVE, 8'd64,  32'h0);
    queue_req(OP_LOOKUP, 8'd128, 32'h0);
    queue_req(OP_LOOKUP, 8'd64,  32'h0);
    queue_req(OP_INSERT, 8'd192, 32'h5A5A_5A5A);
    queue_req(OP_LOOKUP, 8'd192, 32'h0);
    queue_req(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 8'd255, 32'h0);
    queue_req(OP_INSERT, 8'd255, 32'h0);
    queue_req(OP_LOOKUP, 8'd255, 32'h0);
    queue_req(OP_REMOVE, 8'd0,   32'h0);
    queue_req(OP_REMOVE, 8'd0,   32'h0);
    queue_req(OP_LOOKUP, 8'd0,   32'h0);
    queue_req(OP_UNUSED, 8'd0,   32'h0);

    // Zero cap: every new key is refused, existing keys still overwrite
    run_phase(0, 40, 256, 50, 16, 16);

    // Cap above the slot count: fill every slot with distinct keys so the
    // last inserts fail by probe exhaustion and misses walk the whole chain.
    // No idling on either side here.
    run_phase(127, 0, 256, 70, 0, 0);
    for (int i = 0; i < 72; i++)
      queue_req(OP_INSERT, KEY_W'(i * 3), $urandom());
    for (int i = 0; i < 8; i++)
      queue_req(OP_LOOKUP, KEY_W'(i * 3 + 1), 32'h0);
    queue_mix(220, 256, 60);

    run_phase(64, 250, 96, 40, 16, 16);
    run_phase(1, 100, 16, 50, 4, 16);
    run_phase(20, 300, 48, 45, 16, 0);
    run_phase(MAX_ENTRIES_RST, 300, 128, 45, 0, 16);
    run_phase($urandom_range(1, 127), 300, 256, 45, 16, 16);

    // Final batch: stall the response side for a long stretch while the
    // sender keeps offering, so the table backs up and drops in_ready
    run_phase(64, 360, 200, 45, 2, 16);
    hold_requests++;

    wait_drained();
    repeat (2 * SLOTS_DEF + 8) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #(15_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
